// ===== hw/rtl/tpcr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpcr_pkg
// Shared types and constants of the trusted proxy client resolver.
// ----------------------------------------------------------------------------
package tpcr_pkg;

    localparam int NETWORKS = 16;
    localparam int IDX_W    = (NETWORKS > 1) ? $clog2(NETWORKS) : 1;

    localparam int ADDR_W   = 128;
    localparam int IN_W     = 144;
    localparam int OUT_W    = 136;

    localparam logic [7:0]  PFX_V4     = 8'd32;
    localparam logic [7:0]  PFX_V6     = 8'd128;
    localparam logic [7:0]  PFX_MAPPED = 8'd96;
    localparam logic [31:0] MAPPED_TAG = 32'h0000_ffff;

    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_PEER  = 2'd1,
        KIND_FWD   = 2'd2,
        KIND_QUERY = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        STS_ACCEPT    = 3'd0,
        STS_REJECT    = 3'd1,
        STS_RESOLVED  = 3'd2,
        STS_NO_CLIENT = 3'd3,
        STS_QUERY     = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        SRC_NONE = 2'd0,
        SRC_IN   = 2'd1,
        SRC_CUR  = 2'd2
    } t_src;

    typedef struct packed {
        logic    load_in;
        logic    tbl_write;
        logic    tbl_clear;
        logic    cur_load;
        logic    out_load;
        t_status out_status;
        t_src    out_src;
        logic    out_trusted;
    } t_cmd;

    typedef struct packed {
        t_kind kind;
        logic  valid;
        logic  last;
        logic  hit;
        logic  slot_ok;
        logic  wr_ok;
        logic  out_free;
    } t_sts;

endpackage

// ===== hw/rtl/tpcr_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpcr_dpath
// Input register with address normalization, trusted network table with
// parallel match, current client register and output register.
// ----------------------------------------------------------------------------
module tpcr_dpath (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [tpcr_pkg::IN_W-1:0]  i_s_tdata,
    input  logic [1:0]                 i_s_tuser,
    input  logic                       i_s_tlast,
    input  logic                       i_m_tready,
    input  tpcr_pkg::t_cmd             i_cmd,
    output tpcr_pkg::t_sts             o_sts,
    output logic                       o_m_tvalid,
    output logic [tpcr_pkg::OUT_W-1:0] o_m_tdata,
    output logic [2:0]                 o_m_tuser
);

    // input fields
    logic [3:0]                  in_slot;
    logic [63:0]                 in_hi;
    logic [63:0]                 in_lo;
    logic                        in_v6;
    logic [7:0]                  in_plen;
    logic                        in_valid;
    logic                        in_mapped;
    logic [tpcr_pkg::ADDR_W-1:0] n_addr;
    logic                        n_v6;

    assign in_slot  = i_s_tdata[3:0];
    assign in_hi    = i_s_tdata[67:4];
    assign in_lo    = i_s_tdata[131:68];
    assign in_v6    = i_s_tdata[132];
    assign in_plen  = i_s_tdata[140:133];
    assign in_valid = i_s_tdata[141];

    assign in_mapped = in_v6 && (in_hi == 64'd0) && (in_lo[63:32] == tpcr_pkg::MAPPED_TAG);

    always_comb begin
        if (in_mapped) begin
            n_addr = {in_lo[31:0], 96'd0};
            n_v6   = 1'b0;
        end else if (in_v6) begin
            n_addr = {in_hi, in_lo};
            n_v6   = 1'b1;
        end else begin
            n_addr = {in_hi[63:32], 96'd0};
            n_v6   = 1'b0;
        end
    end

    tpcr_pkg::t_kind             r_kind;
    logic [3:0]                  r_slot;
    logic [tpcr_pkg::ADDR_W-1:0] r_addr;
    logic                        r_v6;
    logic                        r_mapped;
    logic [7:0]                  r_plen;
    logic                        r_valid;
    logic                        r_last;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_kind   <= tpcr_pkg::t_kind'(i_s_tuser);
            r_slot   <= in_slot;
            r_addr   <= n_addr;
            r_v6     <= n_v6;
            r_mapped <= in_mapped;
            r_plen   <= in_plen;
            r_valid  <= in_valid;
            r_last   <= i_s_tlast;
        end
    end

    // write checks and mask
    logic [7:0]                  pfx_eff;
    logic                        wr_ok;
    logic                        slot_ok;
    logic [tpcr_pkg::IDX_W-1:0]  wr_idx;
    logic [tpcr_pkg::ADDR_W-1:0] wr_mask;

    always_comb begin
        pfx_eff = r_mapped ? (r_plen - tpcr_pkg::PFX_MAPPED) : r_plen;
        if (r_mapped) begin
            wr_ok = (r_plen >= tpcr_pkg::PFX_MAPPED) && (r_plen <= tpcr_pkg::PFX_V6);
        end else begin
            wr_ok = r_plen <= (r_v6 ? tpcr_pkg::PFX_V6 : tpcr_pkg::PFX_V4);
        end
        slot_ok = 32'(r_slot) < tpcr_pkg::NETWORKS;
        wr_idx  = tpcr_pkg::IDX_W'(r_slot);
        if (pfx_eff == 8'd0) begin
            wr_mask = '0;
        end else begin
            wr_mask = {tpcr_pkg::ADDR_W{1'b1}} << (tpcr_pkg::PFX_V6 - pfx_eff);
        end
    end

    // network table
    logic [tpcr_pkg::ADDR_W-1:0] r_base [tpcr_pkg::NETWORKS];
    logic [tpcr_pkg::ADDR_W-1:0] r_mask [tpcr_pkg::NETWORKS];
    logic [tpcr_pkg::NETWORKS-1:0] r_fam;
    logic [tpcr_pkg::NETWORKS-1:0] r_used;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else if (i_cmd.tbl_clear) begin
            r_used[wr_idx] <= 1'b0;
        end else if (i_cmd.tbl_write) begin
            r_used[wr_idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.tbl_write) begin
            r_base[wr_idx] <= r_addr;
            r_mask[wr_idx] <= wr_mask;
            r_fam[wr_idx]  <= r_v6;
        end
    end

    logic [tpcr_pkg::NETWORKS-1:0] match;

    always_comb begin
        for (int i = 0; i < tpcr_pkg::NETWORKS; i++) begin
            match[i] = r_used[i] && (r_fam[i] == r_v6) &&
                       (((r_base[i] ^ r_addr) & r_mask[i]) == '0);
        end
    end

    // current client
    logic [tpcr_pkg::ADDR_W-1:0] r_cur_addr;
    logic                        r_cur_v6;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_addr <= '0;
            r_cur_v6   <= 1'b0;
        end else if (i_cmd.cur_load) begin
            r_cur_addr <= r_addr;
            r_cur_v6   <= r_v6;
        end
    end

    // output register
    logic                        r_out_valid;
    tpcr_pkg::t_status           r_out_status;
    logic [tpcr_pkg::ADDR_W-1:0] r_out_addr;
    logic                        r_out_v6;
    logic                        r_out_trusted;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_status  <= i_cmd.out_status;
            r_out_trusted <= i_cmd.out_trusted;
            case (i_cmd.out_src)
                tpcr_pkg::SRC_IN: begin
                    r_out_addr <= r_addr;
                    r_out_v6   <= r_v6;
                end
                tpcr_pkg::SRC_CUR: begin
                    r_out_addr <= r_cur_addr;
                    r_out_v6   <= r_cur_v6;
                end
                default: begin
                    r_out_addr <= '0;
                    r_out_v6   <= 1'b0;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_status;
    assign o_m_tdata  = {6'd0, r_out_trusted, r_out_v6,
                         r_out_addr[63:0], r_out_addr[127:64]};

    assign o_sts.kind     = r_kind;
    assign o_sts.valid    = r_valid;
    assign o_sts.last     = r_last;
    assign o_sts.hit      = |match;
    assign o_sts.slot_ok  = slot_ok;
    assign o_sts.wr_ok    = wr_ok;
    assign o_sts.out_free = !r_out_valid || i_m_tready;

endmodule

// ===== hw/rtl/tpcr_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpcr_ctrl
// Controller: input handshake, per-kind decisions and the forwarded walk.
// ----------------------------------------------------------------------------
module tpcr_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_tvalid,
    output logic           o_s_tready,
    input  tpcr_pkg::t_sts i_sts,
    output tpcr_pkg::t_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EVAL = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_walk;
    logic   n_walk;

    tpcr_pkg::t_cmd cmd;
    logic           has_res;

    always_comb begin
        cmd         = '0;
        cmd.out_status  = tpcr_pkg::STS_ACCEPT;
        cmd.out_src     = tpcr_pkg::SRC_NONE;
        has_res     = 1'b0;
        n_walk      = r_walk;
        n_state     = r_state;
        cmd.load_in = (r_state == S_IDLE) && i_s_tvalid;

        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                case (i_sts.kind)
                    tpcr_pkg::KIND_WRITE: begin
                        has_res = 1'b1;
                        if (!i_sts.slot_ok) begin
                            cmd.out_status = tpcr_pkg::STS_REJECT;
                        end else if (!i_sts.valid) begin
                            cmd.tbl_clear = 1'b1;
                        end else if (i_sts.wr_ok) begin
                            cmd.tbl_write = 1'b1;
                        end else begin
                            cmd.out_status = tpcr_pkg::STS_REJECT;
                        end
                    end
                    tpcr_pkg::KIND_QUERY: begin
                        has_res         = 1'b1;
                        cmd.out_status  = tpcr_pkg::STS_QUERY;
                        cmd.out_trusted = i_sts.valid && i_sts.hit;
                    end
                    tpcr_pkg::KIND_PEER: begin
                        n_walk = 1'b0;
                        if (!i_sts.valid) begin
                            has_res        = 1'b1;
                            cmd.out_status = tpcr_pkg::STS_NO_CLIENT;
                        end else begin
                            cmd.cur_load = 1'b1;
                            if (i_sts.last || !i_sts.hit) begin
                                has_res        = 1'b1;
                                cmd.out_status = tpcr_pkg::STS_RESOLVED;
                                cmd.out_src    = tpcr_pkg::SRC_IN;
                            end else begin
                                n_walk = 1'b1;
                            end
                        end
                    end
                    tpcr_pkg::KIND_FWD: begin
                        if (r_walk) begin
                            if (!i_sts.valid) begin
                                n_walk         = 1'b0;
                                has_res        = 1'b1;
                                cmd.out_status = tpcr_pkg::STS_RESOLVED;
                                cmd.out_src    = tpcr_pkg::SRC_CUR;
                            end else begin
                                cmd.cur_load = 1'b1;
                                if (i_sts.last || !i_sts.hit) begin
                                    n_walk         = 1'b0;
                                    has_res        = 1'b1;
                                    cmd.out_status = tpcr_pkg::STS_RESOLVED;
                                    cmd.out_src    = tpcr_pkg::SRC_IN;
                                end
                            end
                        end
                    end
                    default: begin
                        has_res = 1'b0;
                    end
                endcase

                if (has_res && !i_sts.out_free) begin
                    // hold the beat until the output register drains
                    cmd         = '0;
                    n_walk      = r_walk;
                end else begin
                    cmd.out_load = has_res;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_walk  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_walk  <= n_walk;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_cmd      = cmd;

endmodule

// ===== hw/rtl/trusted_proxy_client_resolver.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trusted_proxy_client_resolver
// A result beat is loaded into the output register in the evaluation state
// after the input register; a new beat is taken once the last is evaluated.
// A finished result waits in the output register while the next beat enters.
// Reset (synchronous, active low) clears the table, the walk and the output.
// Resolves the client address behind trusted proxies from forwarded entries.
// ----------------------------------------------------------------------------
module trusted_proxy_client_resolver (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_tvalid,
    output logic                       o_s_tready,
    // slot, addr_hi, addr_lo, is_v6, prefix_len, entry_valid, zero pad
    input  logic [tpcr_pkg::IN_W-1:0]  i_s_tdata,
    // kind
    input  logic [1:0]                 i_s_tuser,
    input  logic                       i_s_tlast,
    output logic                       o_m_tvalid,
    input  logic                       i_m_tready,
    // client_hi, client_lo, client_is_v6, trusted, zero pad
    output logic [tpcr_pkg::OUT_W-1:0] o_m_tdata,
    // status
    output logic [2:0]                 o_m_tuser
);

    tpcr_pkg::t_cmd cmd;
    tpcr_pkg::t_sts sts;

    tpcr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    tpcr_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_s_tlast  (i_s_tlast),
        .i_m_tready (i_m_tready),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

endmodule

// ===== test/trusted_proxy_client_resolver_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trusted_proxy_client_resolver_tb
// Checks the trusted proxy client resolver against a cycle-free predictor.
// A directed opening covers the table write rules, the IPv4-mapped forms,
// queries and every way a walk can end. A random phase of about 1000 beats
// follows, mostly well-formed request chains with hits in the table, plus
// queries, table writes and stray forwarded entries. Both stream sides idle
// at random, and the result side holds off once long enough to stall input.
// ----------------------------------------------------------------------------
module trusted_proxy_client_resolver_tb;
    import tpcr_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 1000;
    localparam int HOLD_OFF       = 64;

    typedef struct {
        t_kind       kind;
        logic [3:0]  slot;
        logic [63:0] addr_hi;
        logic [63:0] addr_lo;
        logic        is_v6;
        logic [7:0]  prefix_len;
        logic        entry_valid;
        logic        last;
    } t_req_beat;

    typedef struct {
        t_status     status;
        logic [63:0] client_hi;
        logic [63:0] client_lo;
        logic        client_is_v6;
        logic        trusted;
    } t_answer;

    class client_resolve_scoreboard;
        logic [63:0] base_hi [NETWORKS];
        logic [63:0] base_lo [NETWORKS];
        logic        fam_v6  [NETWORKS];
        logic [7:0]  pfx     [NETWORKS];
        logic        used    [NETWORKS];
        logic        walking;
        logic [63:0] held_hi;
        logic [63:0] held_lo;
        logic        held_v6;
        t_answer     pending_answers [$];
        int          mismatches;
        int          beats_taken;
        int          answers_checked;
        int          clients_resolved;
        int          trusted_hits;
        int          writes_rejected;

        function new();
            foreach (used[i]) begin
                base_hi[i] = '0;
                base_lo[i] = '0;
                fam_v6[i]  = 1'b0;
                pfx[i]     = '0;
                used[i]    = 1'b0;
            end
            walking = 1'b0;
            held_hi = '0;
            held_lo = '0;
            held_v6 = 1'b0;
        endfunction

        function logic [127:0] prefix_mask(logic [7:0] p);
            return (p == 0) ? '0 : (~128'h0 << (128 - int'(p)));
        endfunction

        function bit in_trusted_net(logic [63:0] hi, logic [63:0] lo, logic v6);
            foreach (used[i]) begin
                if (used[i] && fam_v6[i] == v6 &&
                    ((({base_hi[i], base_lo[i]} ^ {hi, lo}) & prefix_mask(pfx[i])) == '0))
                    return 1'b1;
            end
            return 1'b0;
        endfunction

        function void expect_answer(t_status st, logic [63:0] hi, logic [63:0] lo,
                                    logic v6, logic tr);
            t_answer a;
            a.status       = st;
            a.client_hi    = hi;
            a.client_lo    = lo;
            a.client_is_v6 = v6;
            a.trusted      = tr;
            pending_answers = {pending_answers, a};
            if (st == STS_RESOLVED) clients_resolved++;
            if (st == STS_REJECT) writes_rejected++;
        endfunction

        function void take_request(t_req_beat b);
            logic [63:0] hi;
            logic [63:0] lo;
            logic        v6;
            logic [7:0]  pl;
            bit          mapped;
            bit          hit;
            hi     = b.addr_hi;
            lo     = b.addr_lo;
            v6     = b.is_v6;
            pl     = b.prefix_len;
            mapped = 1'b0;
            beats_taken++;
            // ::ffff:a.b.c.d folds to IPv4; IPv4 keeps only its top 32 bits
            if (v6) begin
                if (hi == '0 && lo[63:32] == MAPPED_TAG) begin
                    hi     = {lo[31:0], 32'h0};
                    lo     = '0;
                    v6     = 1'b0;
                    mapped = 1'b1;
                end
            end else begin
                hi = {hi[63:32], 32'h0};
                lo = '0;
            end
            case (b.kind)
                KIND_WRITE: begin
                    if (int'(b.slot) >= NETWORKS) begin
                        expect_answer(STS_REJECT, '0, '0, 1'b0, 1'b0);
                    end else if (!b.entry_valid) begin
                        used[b.slot] = 1'b0;
                        expect_answer(STS_ACCEPT, '0, '0, 1'b0, 1'b0);
                    end else if (mapped ? (pl < PFX_MAPPED || pl > PFX_V6)
                                        : (pl > (v6 ? PFX_V6 : PFX_V4))) begin
                        expect_answer(STS_REJECT, '0, '0, 1'b0, 1'b0);
                    end else begin
                        base_hi[b.slot] = hi;
                        base_lo[b.slot] = lo;
                        fam_v6[b.slot]  = v6;
                        pfx[b.slot]     = mapped ? pl - PFX_MAPPED : pl;
                        used[b.slot]    = 1'b1;
                        expect_answer(STS_ACCEPT, '0, '0, 1'b0, 1'b0);
                    end
                end
                KIND_QUERY: begin
                    hit = b.entry_valid && in_trusted_net(hi, lo, v6);
                    if (hit) trusted_hits++;
                    expect_answer(STS_QUERY, '0, '0, 1'b0, hit);
                end
                KIND_PEER: begin
                    walking = 1'b0;
                    if (!b.entry_valid) begin
                        expect_answer(STS_NO_CLIENT, '0, '0, 1'b0, 1'b0);
                    end else begin
                        held_hi = hi;
                        held_lo = lo;
                        held_v6 = v6;
                        if (b.last || !in_trusted_net(hi, lo, v6))
                            expect_answer(STS_RESOLVED, hi, lo, v6, 1'b0);
                        else
                            walking = 1'b1;
                    end
                end
                KIND_FWD: begin
                    if (walking) begin
                        if (!b.entry_valid) begin
                            walking = 1'b0;
                            expect_answer(STS_RESOLVED, held_hi, held_lo, held_v6, 1'b0);
                        end else begin
                            held_hi = hi;
                            held_lo = lo;
                            held_v6 = v6;
                            if (b.last || !in_trusted_net(hi, lo, v6)) begin
                                walking = 1'b0;
                                expect_answer(STS_RESOLVED, hi, lo, v6, 1'b0);
                            end
                        end
                    end
                end
            endcase
        endfunction

        function void compare_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
            if (act_v !== exp_v) begin
                $error("%s: expected %0h, got %0h", name, exp_v, act_v);
                mismatches++;
            end
        endfunction

        function void check_answer(logic [2:0] st, logic [OUT_W-1:0] d);
            t_answer a;
            if (pending_answers.size() == 0) begin
                $error("answer beat with none pending: status %0d", st);
                mismatches++;
                return;
            end
            a = pending_answers.pop_front();
            answers_checked++;
            compare_field("status", 64'(a.status), 64'(st));
            compare_field("client_hi", a.client_hi, d[63:0]);
            compare_field("client_lo", a.client_lo, d[127:64]);
            compare_field("client_is_v6", 64'(a.client_is_v6), 64'(d[128]));
            compare_field("trusted", 64'(a.trusted), 64'(d[129]));
        endfunction
    endclass

    logic             i_clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             m_tready = 1'b0;
    t_req_beat        beat;
    logic             o_s_tready;
    logic             o_m_tvalid;
    logic [OUT_W-1:0] o_m_tdata;
    logic [2:0]       o_m_tuser;
    logic [IN_W-1:0]  s_tdata;

    client_resolve_scoreboard sb;
    bit idle_on = 1'b1;
    int items_sent;
    int answers_seen;
    int stall_cycles;

    assign s_tdata = {2'b00, beat.entry_valid, beat.prefix_len, beat.is_v6,
                      beat.addr_lo, beat.addr_hi, beat.slot};

    trusted_proxy_client_resolver uut (
        .i_clk      (i_clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (beat.kind),
        .i_s_tlast  (beat.last),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (rst_n && s_tvalid && o_s_tready) sb.take_request(beat);
        if (rst_n && o_m_tvalid && m_tready) begin
            sb.check_answer(o_m_tuser, o_m_tdata);
            answers_seen++;
        end
    end

    always @(posedge i_clk) begin
        if (!rst_n || (s_tvalid && o_s_tready) || (o_m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("[trusted_proxy_client_resolver] ERROR");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // result side: random stalls, and one long hold-off to back up the input
    initial begin : result_sink
        int  wait_cycles;
        bit  held_off;
        held_off = 1'b0;
        while (!rst_n) @(posedge i_clk);
        forever begin
            if (!held_off && answers_seen >= 200) begin
                held_off    = 1'b1;
                wait_cycles = HOLD_OFF;
            end else begin
                wait_cycles = idle_on ? $urandom_range(0, 7) : 0;
            end
            if (wait_cycles > 0) begin
                m_tready <= 1'b0;
                repeat (wait_cycles) @(posedge i_clk);
            end
            m_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
        end
    end

    task automatic push_beat(input t_kind k, input logic [3:0] sl, input logic [63:0] hi,
                             input logic [63:0] lo, input logic v6, input logic [7:0] pl,
                             input logic ok, input logic lst);
        int gap;
        gap = idle_on ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        beat     <= '{kind: k, slot: sl, addr_hi: hi, addr_lo: lo, is_v6: v6,
                      prefix_len: pl, entry_valid: ok, last: lst};
        s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    // hit: try to land inside an enabled network; IPv4 sometimes as ::ffff:a.b.c.d
    function automatic void pick_addr(input bit hit, output logic [63:0] hi,
                                      output logic [63:0] lo, output logic v6);
        int           idx;
        logic [127:0] rnd;
        logic [127:0] full;
        logic [127:0] m;
        rnd  = {$urandom, $urandom, $urandom, $urandom};
        full = rnd;
        v6   = 1'($urandom_range(0, 1));
        if (hit) begin
            idx = $urandom_range(0, NETWORKS - 1);
            for (int n = 0; n < NETWORKS && !sb.used[idx]; n++)
                idx = (idx + 1) % NETWORKS;
            if (sb.used[idx]) begin
                v6   = sb.fam_v6[idx];
                m    = sb.prefix_mask(sb.pfx[idx]);
                full = ({sb.base_hi[idx], sb.base_lo[idx]} & m) | (rnd & ~m);
            end
        end
        if (v6) begin
            {hi, lo} = full;
        end else if ($urandom_range(0, 3) == 0) begin
            hi = '0;
            lo = {MAPPED_TAG, full[127:96]};
            v6 = 1'b1;
        end else begin
            hi = {full[127:96], 32'($urandom)};
            lo = {$urandom, $urandom};
        end
    endfunction

    task automatic random_write();
        logic [63:0] hi;
        logic [63:0] lo;
        logic        v6;
        logic [7:0]  pl;
        int          r;
        r  = $urandom_range(0, 9);
        hi = {$urandom, $urandom};
        lo = {$urandom, $urandom};
        v6 = (r >= 5);
        pl = v6 ? 8'($urandom_range(16, 64)) : 8'($urandom_range(8, 28));
        if (r == 9) begin
            hi = '0;
            lo = {MAPPED_TAG, 32'($urandom)};
            pl = 8'($urandom_range(92, 132));
        end else if (r == 8) begin
            pl = 8'($urandom_range(0, 255));
        end else if (r == 7) begin
            pl = v6 ? PFX_V6 : PFX_V4;
        end
        push_beat(KIND_WRITE, 4'($urandom_range(0, 15)), hi, lo, v6, pl,
                  $urandom_range(0, 7) != 0, 1'($urandom_range(0, 1)));
    endtask

    task automatic random_request();
        int          hops;
        int          j;
        bit          drop_last;
        logic [63:0] hi;
        logic [63:0] lo;
        logic        v6;
        hops      = $urandom_range(0, 5);
        drop_last = ($urandom_range(0, 11) == 0);
        pick_addr($urandom_range(0, 4) != 0, hi, lo, v6);
        push_beat(KIND_PEER, 4'($urandom_range(0, 15)), hi, lo, v6,
                  8'($urandom_range(0, 255)),
                  $urandom_range(0, 15) != 0, hops == 0 && !drop_last);
        for (j = 0; j < hops; j++) begin
            pick_addr((j < hops - 1) ? ($urandom_range(0, 5) != 0)
                                     : 1'($urandom_range(0, 1)),
                      hi, lo, v6);
            push_beat(KIND_FWD, 4'($urandom_range(0, 15)), hi, lo, v6,
                      8'($urandom_range(0, 255)),
                      $urandom_range(0, 13) != 0, j == hops - 1 && !drop_last);
        end
        items_sent += hops + 1;
    endtask

    initial begin : stimulus
        int          sel;
        int          next_flip;
        logic [63:0] hi;
        logic [63:0] lo;
        logic        v6;
        sb   = new();
        beat = '{kind: KIND_WRITE, slot: '0, addr_hi: '0, addr_lo: '0, is_v6: 1'b0,
                 prefix_len: '0, entry_valid: 1'b0, last: 1'b0};
        repeat (6) @(posedge i_clk);
        rst_n <= 1'b1;

        // table writes: plain, mapped, rejected prefixes, host and catch-all nets
        push_beat(KIND_WRITE, 4'd0, 64'h0a00_0000_0000_0000, '0, 1'b0, 8'd8, 1'b1, 1'b0);
        push_beat(KIND_WRITE, 4'd1, 64'h2001_0db8_0000_0000, '0, 1'b1, 8'd32, 1'b1, 1'b0);
        push_beat(KIND_WRITE, 4'd2, '0, 64'h0000_ffff_c0a8_0000, 1'b1, 8'd112, 1'b1, 1'b0);
        push_beat(KIND_WRITE, 4'd3, '0, 64'h0000_ffff_0102_0304, 1'b1, 8'd95, 1'b1, 1'b0);
        push_beat(KIND_WRITE, 4'd3, '0, 64'h0000_ffff_0102_0304, 1'b1, 8'd129, 1'b1, 1'b0);
        push_beat(KIND_WRITE, 4'd3, '0, 64'h0000_ffff_0102_0304, 1'b1, 8'd128, 1'b1, 1'b0);
        push_beat(KIND_WRITE, 4'd4, 64'hc633_6407_0000_0000, '0, 1'b0, 8'd33, 1'b1, 1'b0);
        push_beat(KIND_WRITE, 4'd4, 64'hc633_6407_dead_beef, '1, 1'b0, 8'd32, 1'b1, 1'b1);
        push_beat(KIND_WRITE, 4'd5, '1, '1, 1'b1, 8'd129, 1'b1, 1'b0);
        push_beat(KIND_WRITE, 4'd5, '1, '1, 1'b1, 8'd255, 1'b1, 1'b0);
        push_beat(KIND_WRITE, 4'd15, '1, '1, 1'b1, 8'd128, 1'b1, 1'b0);
        push_beat(KIND_WRITE, 4'd14, '0, 64'h0000_ffff_0000_0000, 1'b1, 8'd96, 1'b1, 1'b0);
        // queries, with the IPv4 catch-all in place and after it is disabled
        push_beat(KIND_QUERY, 4'd0, 64'h0808_0808_0000_0000, '0, 1'b0, 8'd0, 1'b1, 1'b0);
        push_beat(KIND_WRITE, 4'd14, '0, '0, 1'b0, 8'd0, 1'b0, 1'b0);
        push_beat(KIND_QUERY, 4'd0, 64'h0808_0808_0000_0000, '0, 1'b0, 8'd0, 1'b1, 1'b0);
        push_beat(KIND_QUERY, 4'd0, 64'h0a01_0203_ffff_ffff, '1, 1'b0, 8'd0, 1'b1, 1'b0);
        push_beat(KIND_QUERY, 4'd0, '1, '1, 1'b1, 8'd255, 1'b1, 1'b1);
        push_beat(KIND_QUERY, 4'd0, '0, '0, 1'b1, 8'd0, 1'b1, 1'b0);
        push_beat(KIND_QUERY, 4'd0, '1, '1, 1'b1, 8'd0, 1'b0, 1'b0);
        // peers: invalid, untrusted, trusted with last
        push_beat(KIND_PEER, 4'd0, 64'h0a00_0001_0000_0000, '0, 1'b0, 8'd0, 1'b0, 1'b0);
        push_beat(KIND_PEER, 4'd0, 64'h0808_0808_0000_0000, '0, 1'b0, 8'd0, 1'b1, 1'b0);
        push_beat(KIND_PEER, 4'd0, 64'h0a00_0001_0000_0000, '0, 1'b0, 8'd0, 1'b1, 1'b1);
        // walk through v6 and mapped proxies to an untrusted client
        push_beat(KIND_PEER, 4'd0, 64'h0a00_0001_0000_0000, '0, 1'b0, 8'd0, 1'b1, 1'b0);
        push_beat(KIND_FWD, 4'd0, 64'h2001_0db8_0000_0000, 64'h1, 1'b1, 8'd0, 1'b1, 1'b0);
        push_beat(KIND_FWD, 4'd0, '0, 64'h0000_ffff_c0a8_0304, 1'b1, 8'd0, 1'b1, 1'b0);
        push_beat(KIND_FWD, 4'd0, 64'hcb00_7109_0000_0000, '0, 1'b0, 8'd0, 1'b1, 1'b0);
        // malformed hop, stray hop while idle, peer restarting a walk, last hop
        push_beat(KIND_PEER, 4'd0, 64'h0a00_0002_0000_0000, '0, 1'b0, 8'd0, 1'b1, 1'b0);
        push_beat(KIND_FWD, 4'd0, 64'h0101_0101_0000_0000, '0, 1'b0, 8'd0, 1'b0, 1'b0);
        push_beat(KIND_FWD, 4'd0, 64'h0a00_0003_0000_0000, '0, 1'b0, 8'd0, 1'b1, 1'b1);
        push_beat(KIND_PEER, 4'd0, 64'h0a09_0909_0000_0000, '0, 1'b0, 8'd0, 1'b1, 1'b0);
        push_beat(KIND_PEER, 4'd0, 64'h0808_0404_0000_0000, '0, 1'b0, 8'd0, 1'b1, 1'b0);
        push_beat(KIND_PEER, 4'd0, 64'h2001_0db8_0000_0000, 64'h5, 1'b1, 8'd0, 1'b1, 1'b0);
        push_beat(KIND_FWD, 4'd0, 64'h0a03_0303_0000_0000, '0, 1'b0, 8'd0, 1'b1, 1'b1);

        repeat (8) random_write();
        items_sent = 0;
        next_flip  = 0;
        while (items_sent < RANDOM_ITEMS) begin
            if (items_sent >= next_flip) begin
                idle_on   = ($urandom_range(0, 3) != 0);
                next_flip = items_sent + 80;
            end
            sel = $urandom_range(0, 19);
            if (sel < 13) begin
                random_request();
            end else if (sel < 16) begin
                pick_addr(sel < 15, hi, lo, v6);
                push_beat(KIND_QUERY, 4'($urandom_range(0, 15)), hi, lo, v6,
                          8'($urandom_range(0, 255)), $urandom_range(0, 15) != 0,
                          1'($urandom_range(0, 1)));
                items_sent++;
            end else if (sel < 19) begin
                random_write();
                items_sent++;
            end else begin
                pick_addr(1'($urandom_range(0, 1)), hi, lo, v6);
                push_beat(KIND_FWD, 4'($urandom_range(0, 15)), hi, lo, v6,
                          8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)));
            end
        end
        s_tvalid <= 1'b0;

        while (sb.pending_answers.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        $display("covered %0d request beats, %0d answer beats: %0d clients resolved,",
                 sb.beats_taken, sb.answers_checked, sb.clients_resolved);
        $display("%0d trusted query hits, %0d rejected table writes, one long result stall",
                 sb.trusted_hits, sb.writes_rejected);
        if (sb.mismatches == 0) begin
            $display("[trusted_proxy_client_resolver] OK");
        end else begin
            $display("[trusted_proxy_client_resolver] ERROR");
        end
        $finish;
    end

endmodule
